FILE: src/bsr_pkg.sv
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared widths, constants and types of the bisection square root block.
// ----------------------------------------------------------------------------
package bsr_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int MAX_ITER  = 48;

    localparam int ITER_W = $clog2(MAX_ITER + 1);
    localparam int TGT_W  = DATA_W + FRAC_BITS;
    localparam int BND_W  = TGT_W + 1;
    localparam int SQ_W   = 2 * DATA_W;

    localparam logic [DATA_W-1:0] ONE_FX    = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic [DATA_W-1:0] TOL_RESET = DATA_W'(6554);
    localparam logic [ITER_W-1:0] ITER_CAP  = ITER_W'(MAX_ITER);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SETUP = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_CMP   = 5'b01000,
        ST_FIN   = 5'b10000
    } bsr_state_t;

    typedef struct packed {
        logic [DATA_W-1:0] root;
        logic              limit_hit;
    } bsr_result_t;

endpackage

FILE: src/bisection_square_root.sv
// ----------------------------------------------------------------------------
// bisection_square_root
// Square root of an unsigned Q16.16 value by interval halving.
// ----------------------------------------------------------------------------
// Input stream s_axis carries value_in in tdata; each request yields one
// result on m_axis: root_out in tdata, limit_hit in tuser.
// cfg_wr_en/cfg_wr_data write the tolerance (Q16.16, reset 6554); write it
// only while no request is in flight.
// Zero and one are answered directly from setup. Other values run k steps,
// k the number of midpoints tried (up to 48). Each step passes through the
// shared squarer (ST_MUL) and then the compare and interval update
// (ST_CMP).
// One request at a time: s_axis_tready is high only while the sequencer is
// idle. A finished result sits in the output register, so the next request
// is taken while it waits. If the receiver stalls with the output register
// full, the next finished result holds in the sequencer and no further
// request is taken. Reset empties the output register, idles the sequencer
// and restores the tolerance.
// ----------------------------------------------------------------------------
module bisection_square_root
    import bsr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] value_in
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] root_out
    output logic              m_axis_tuser,   // [0] limit_hit
    input  logic              cfg_wr_en,
    input  logic [DATA_W-1:0] cfg_wr_data
);

    logic [DATA_W-1:0] tolerance_reg;
    logic              m_valid_reg;
    bsr_result_t       m_res_reg;

    logic              core_idle;
    logic              res_valid;
    logic              slot_free;
    bsr_result_t       result;

    assign slot_free = !m_valid_reg || m_axis_tready;

    bsr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_axis_tvalid && core_idle),
        .value     (s_axis_tdata),
        .tolerance (tolerance_reg),
        .idle      (core_idle),
        .res_valid (res_valid),
        .res_ready (slot_free),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= TOL_RESET;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                tolerance_reg <= cfg_wr_data;
            end
            if (slot_free)
            begin
                m_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && res_valid)
        begin
            m_res_reg <= result;
        end
    end

    assign s_axis_tready = core_idle;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_res_reg.root;
    assign m_axis_tuser  = m_res_reg.limit_hit;

endmodule

FILE: src/bsr_square_unit.sv
// ----------------------------------------------------------------------------
// bsr_square_unit
// Registered squarer shared by every bisection step.
// ----------------------------------------------------------------------------
module bsr_square_unit
    import bsr_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [DATA_W-1:0] x,
    output logic [SQ_W-1:0]   sq
);

    logic [SQ_W-1:0] sq_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= SQ_W'(x) * SQ_W'(x);
        end
    end

    assign sq = sq_reg;

endmodule

FILE: src/bsr_core.sv
// ----------------------------------------------------------------------------
// bsr_core
// Sequencer and interval registers; one square and compare per step.
// ----------------------------------------------------------------------------
module bsr_core
    import bsr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] value,
    input  logic [DATA_W-1:0] tolerance,
    output logic              idle,
    output logic              res_valid,
    input  logic              res_ready,
    output bsr_result_t       result
);

    bsr_state_t        state_reg, state_next;
    logic [DATA_W-1:0] v_reg, v_next;
    logic [DATA_W-1:0] lo_reg, lo_next;
    logic [DATA_W-1:0] hi_reg, hi_next;
    logic [DATA_W-1:0] x_reg, x_next;
    logic [TGT_W-1:0]  tgt_reg, tgt_next;
    logic [BND_W-1:0]  bnd_lo_reg, bnd_lo_next;
    logic [BND_W-1:0]  bnd_hi_reg, bnd_hi_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              limit_reg, limit_next;

    logic [SQ_W-1:0]   sq;
    logic              sq_en;
    logic [TGT_W-1:0]  tgt_w;
    logic [TGT_W-1:0]  tol_w;
    logic [BND_W-1:0]  diff_w;
    logic [DATA_W-1:0] top_w;
    logic              in_tol;
    logic              below;
    logic [DATA_W:0]   sum_up;
    logic [DATA_W:0]   sum_dn;
    logic [ITER_W-1:0] iter_inc;

    bsr_square_unit u_square (
        .clk (clk),
        .en  (sq_en),
        .x   (x_reg),
        .sq  (sq)
    );

    assign tgt_w    = {v_reg, {FRAC_BITS{1'b0}}};
    assign tol_w    = {tolerance, {FRAC_BITS{1'b0}}};
    assign diff_w   = {1'b0, tgt_w} - {1'b0, tol_w};
    assign top_w    = (v_reg > ONE_FX) ? v_reg : ONE_FX;
    assign in_tol   = (sq >= SQ_W'(bnd_lo_reg)) && (sq <= SQ_W'(bnd_hi_reg));
    assign below    = sq < SQ_W'(tgt_reg);
    assign sum_up   = {1'b0, x_reg} + {1'b0, hi_reg};
    assign sum_dn   = {1'b0, lo_reg} + {1'b0, x_reg};
    assign iter_inc = iter_reg + ITER_W'(1);
    assign sq_en    = (state_reg == ST_MUL);

    always_comb
    begin
        state_next  = state_reg;
        v_next      = v_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        x_next      = x_reg;
        tgt_next    = tgt_reg;
        bnd_lo_next = bnd_lo_reg;
        bnd_hi_next = bnd_hi_reg;
        iter_next   = iter_reg;
        limit_next  = limit_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    v_next     = value;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                tgt_next    = tgt_w;
                bnd_lo_next = diff_w[BND_W-1] ? '0 : diff_w;
                bnd_hi_next = {1'b0, tgt_w} + {1'b0, tol_w};
                limit_next  = 1'b0;
                iter_next   = '0;
                if (v_reg == '0)
                begin
                    x_next     = '0;
                    state_next = ST_FIN;
                end
                else if (v_reg == ONE_FX)
                begin
                    x_next     = ONE_FX;
                    state_next = ST_FIN;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = top_w;
                    x_next     = top_w >> 1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                iter_next = iter_inc;
                if (in_tol)
                begin
                    state_next = ST_FIN;
                end
                else if (iter_inc == ITER_CAP)
                begin
                    limit_next = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    if (below)
                    begin
                        lo_next = x_reg;
                        x_next  = sum_up[DATA_W:1];
                    end
                    else
                    begin
                        hi_next = x_reg;
                        x_next  = sum_dn[DATA_W:1];
                    end
                    state_next = ST_MUL;
                end
            end
            ST_FIN:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg      <= v_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        x_reg      <= x_next;
        tgt_reg    <= tgt_next;
        bnd_lo_reg <= bnd_lo_next;
        bnd_hi_reg <= bnd_hi_next;
        iter_reg   <= iter_next;
        limit_reg  <= limit_next;
    end

    assign idle             = (state_reg == ST_IDLE);
    assign res_valid        = (state_reg == ST_FIN);
    assign result.root      = x_reg;
    assign result.limit_hit = limit_reg;

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_CMP) |-> (iter_reg < ITER_CAP))
        else $error("step count beyond cap");

    a_mid_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_CMP) |->
            (lo_reg <= x_reg && x_reg <= hi_reg))
        else $error("midpoint outside interval");

    a_limit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && limit_reg) |-> (iter_reg == ITER_CAP))
        else $error("limit flag without full step count");

    a_sq_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> $past(state_reg == ST_MUL))
        else $error("compare without fresh square");

endmodule
